### sv/modbus_rtu_master_framer_defines.svh
// assertion macros for the modbus rtu master framer
`ifndef MODBUS_RTU_MASTER_FRAMER_DEFINES_SVH
`define MODBUS_RTU_MASTER_FRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MBRTU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mbrtu assertion failed");

// next-cycle implication, checked outside reset
`define MBRTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mbrtu assertion failed");

`endif

### sv/mbrtu_pkg.sv
package mbrtu_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int LEN_W       = 18;

    localparam logic [1:0] ACT_START    = 2'd0;
    localparam logic [1:0] ACT_DATA     = 2'd1;
    localparam logic [1:0] ACT_RESPONSE = 2'd2;

    localparam logic [2:0] KIND_READ_COILS        = 3'd0;
    localparam logic [2:0] KIND_READ_DISCRETE     = 3'd1;
    localparam logic [2:0] KIND_READ_HOLDING_REGS = 3'd2;
    localparam logic [2:0] KIND_READ_INPUT_REGS   = 3'd3;
    localparam logic [2:0] KIND_WRITE_COIL        = 3'd4;
    localparam logic [2:0] KIND_WRITE_REG         = 3'd5;
    localparam logic [2:0] KIND_WRITE_MULTI_COIL  = 3'd6;
    localparam logic [2:0] KIND_WRITE_MULTI_REG   = 3'd7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slave_id;
        logic [2:0]  function_kind;
        logic [15:0] first_addr;
        logic [15:0] quantity_or_value;
        logic [15:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_last;
        logic       response_checked;
        logic       crc_ok;
    } out_item_t;

    typedef enum logic [1:0] {
        ENT_BYTE,
        ENT_CRC_LO,
        ENT_CRC_HI,
        ENT_CHECK
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t  kind;
        logic [7:0] value;
    } entry_t;

    function automatic logic [7:0] fn_code(input logic [2:0] kind);
        logic [7:0] code;
        case (kind)
            KIND_READ_COILS:        code = 8'h01;
            KIND_READ_DISCRETE:     code = 8'h02;
            KIND_READ_HOLDING_REGS: code = 8'h03;
            KIND_READ_INPUT_REGS:   code = 8'h04;
            KIND_WRITE_COIL:        code = 8'h05;
            KIND_WRITE_REG:         code = 8'h06;
            KIND_WRITE_MULTI_COIL:  code = 8'h0F;
            default:                code = 8'h10;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### sv/modbus_rtu_master_framer.sv
// channel   dir   ports                      payload
// input     in    s_valid s_ready s_data     mbrtu_pkg::in_item_t
// result    out   m_valid m_ready m_data     mbrtu_pkg::out_item_t
//
// an item gives 0 to 8 results, one per unstalled cycle, from an entry list
// a transfer fills the entry list, whose first result is then put in m_data
// next item is taken in the cycle the previous item's last entry is emitted
// stalls on m_ready hold the output register and the entry list
// aresetn synchronous, active low; clears all control and protocol state

`include "modbus_rtu_master_framer_defines.svh"

module modbus_rtu_master_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbrtu_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbrtu_pkg::out_item_t m_data
);

    localparam int MaxResults = mbrtu_pkg::MAX_RESULTS;
    localparam int IdxW = mbrtu_pkg::IDX_W;
    localparam int CntW = $clog2(MaxResults + 1);
    localparam int LenW = mbrtu_pkg::LEN_W;

    // protocol state
    logic [15:0]     tx_crc_reg, tx_crc_next;
    logic [15:0]     data_remaining_reg, data_remaining_next;
    logic [2:0]      pending_kind_reg, pending_kind_next;
    logic [LenW-1:0] expected_length_reg, expected_length_next;
    logic [LenW-1:0] received_count_reg, received_count_next;
    logic [15:0]     rx_crc_reg, rx_crc_next;
    logic [15:0]     trailing_pair_reg, trailing_pair_next;
    logic            tx_open_reg, tx_open_next;

    // entry list and emitter
    mbrtu_pkg::entry_t plan_reg [MaxResults];
    mbrtu_pkg::entry_t plan_new [MaxResults];
    logic [CntW-1:0]   new_count;
    logic [IdxW-1:0]   idx_reg, idx_next;
    logic [IdxW-1:0]   last_reg, last_next;
    logic              busy_reg, busy_next;
    logic              m_valid_reg, m_valid_next;
    mbrtu_pkg::out_item_t m_data_reg, m_data_next;

    logic              emit;
    logic              emit_done;
    logic              accept;
    mbrtu_pkg::entry_t cur;

    // decode helpers
    logic [LenW-1:0] q_ext;
    logic [LenW-1:0] coil_bytes;
    logic [LenW-1:0] reg_bytes;
    logic [7:0]      count_octet;
    logic [LenW-1:0] rc_inc;
    logic [7:0]      rx_byte;
    logic [15:0]     trailing_new;

    assign cur       = plan_reg[idx_reg];
    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign emit_done = emit && (idx_reg == last_reg);
    assign s_ready   = !busy_reg || emit_done;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign q_ext        = {{(LenW-16){1'b0}}, s_data.quantity_or_value};
    assign coil_bytes   = (q_ext + LenW'(7)) >> 3;
    assign reg_bytes    = {q_ext[LenW-2:0], 1'b0};
    assign count_octet  = (s_data.function_kind == mbrtu_pkg::KIND_WRITE_MULTI_COIL)
                          ? coil_bytes[7:0] : reg_bytes[7:0];
    assign rc_inc       = received_count_reg + LenW'(1);
    assign rx_byte      = s_data.data_word[7:0];
    assign trailing_new = {rx_byte, trailing_pair_reg[15:8]};

    always_comb begin
        tx_crc_next          = tx_crc_reg;
        data_remaining_next  = data_remaining_reg;
        pending_kind_next    = pending_kind_reg;
        expected_length_next = expected_length_reg;
        received_count_next  = received_count_reg;
        rx_crc_next          = rx_crc_reg;
        trailing_pair_next   = trailing_pair_reg;
        tx_open_next         = tx_open_reg;
        new_count            = '0;
        for (int i = 0; i < MaxResults; i++) begin
            plan_new[i] = '{kind: mbrtu_pkg::ENT_BYTE, value: 8'h00};
        end

        // crc advances as bytes leave
        if (emit && cur.kind == mbrtu_pkg::ENT_BYTE) begin
            tx_crc_next = mbrtu_pkg::crc16_byte(tx_crc_reg, cur.value);
        end

        if (accept) begin
            unique case (s_data.action)
                mbrtu_pkg::ACT_START: begin
                    tx_crc_next         = mbrtu_pkg::CRC_INIT;
                    tx_open_next        = 1'b0;
                    data_remaining_next = '0;
                    pending_kind_next   = s_data.function_kind;
                    received_count_next = '0;
                    rx_crc_next         = mbrtu_pkg::CRC_INIT;
                    trailing_pair_next  = '0;
                    if (s_data.function_kind <= mbrtu_pkg::KIND_READ_DISCRETE) begin
                        expected_length_next = LenW'(5) + coil_bytes;
                    end else if (s_data.function_kind <= mbrtu_pkg::KIND_READ_INPUT_REGS) begin
                        expected_length_next = LenW'(5) + reg_bytes;
                    end else begin
                        expected_length_next = LenW'(8);
                    end
                    plan_new[0].value = s_data.slave_id;
                    plan_new[1].value = mbrtu_pkg::fn_code(s_data.function_kind);
                    plan_new[2].value = s_data.first_addr[15:8];
                    plan_new[3].value = s_data.first_addr[7:0];
                    plan_new[4].value = s_data.quantity_or_value[15:8];
                    plan_new[5].value = s_data.quantity_or_value[7:0];
                    plan_new[6].kind  = mbrtu_pkg::ENT_CRC_LO;
                    plan_new[7].kind  = mbrtu_pkg::ENT_CRC_HI;
                    new_count         = CntW'(8);
                    if (s_data.function_kind == mbrtu_pkg::KIND_WRITE_COIL) begin
                        plan_new[4].value = (s_data.quantity_or_value != 16'h0000)
                                            ? 8'hFF : 8'h00;
                        plan_new[5].value = 8'h00;
                    end else if (s_data.function_kind > mbrtu_pkg::KIND_WRITE_REG) begin
                        plan_new[6] = '{kind: mbrtu_pkg::ENT_BYTE, value: count_octet};
                        new_count   = CntW'(7);
                        data_remaining_next =
                            (s_data.function_kind == mbrtu_pkg::KIND_WRITE_MULTI_COIL)
                            ? coil_bytes[15:0] : s_data.quantity_or_value;
                        tx_open_next = 1'b1;
                    end
                end
                mbrtu_pkg::ACT_DATA: begin
                    if (tx_open_reg) begin
                        if (data_remaining_reg == 16'h0000) begin
                            plan_new[0].kind = mbrtu_pkg::ENT_CRC_LO;
                            plan_new[1].kind = mbrtu_pkg::ENT_CRC_HI;
                            new_count        = CntW'(2);
                            tx_open_next     = 1'b0;
                        end else begin
                            data_remaining_next = data_remaining_reg - 16'd1;
                            if (pending_kind_reg == mbrtu_pkg::KIND_WRITE_MULTI_COIL) begin
                                plan_new[0].value = s_data.data_word[7:0];
                                if (data_remaining_reg == 16'd1) begin
                                    plan_new[1].kind = mbrtu_pkg::ENT_CRC_LO;
                                    plan_new[2].kind = mbrtu_pkg::ENT_CRC_HI;
                                    new_count        = CntW'(3);
                                    tx_open_next     = 1'b0;
                                end else begin
                                    new_count = CntW'(1);
                                end
                            end else begin
                                plan_new[0].value = s_data.data_word[15:8];
                                plan_new[1].value = s_data.data_word[7:0];
                                if (data_remaining_reg == 16'd1) begin
                                    plan_new[2].kind = mbrtu_pkg::ENT_CRC_LO;
                                    plan_new[3].kind = mbrtu_pkg::ENT_CRC_HI;
                                    new_count        = CntW'(4);
                                    tx_open_next     = 1'b0;
                                end else begin
                                    new_count = CntW'(2);
                                end
                            end
                        end
                    end
                end
                mbrtu_pkg::ACT_RESPONSE: begin
                    if (expected_length_reg != '0 &&
                        received_count_reg < expected_length_reg) begin
                        received_count_next = rc_inc;
                        if ({1'b0, rc_inc} + (LenW+1)'(2) <= {1'b0, expected_length_reg}) begin
                            rx_crc_next = mbrtu_pkg::crc16_byte(rx_crc_reg, rx_byte);
                        end
                        trailing_pair_next = trailing_new;
                        if (rc_inc == expected_length_reg) begin
                            plan_new[0] = '{kind: mbrtu_pkg::ENT_CHECK,
                                            value: {7'd0, rx_crc_reg == trailing_new}};
                            new_count   = CntW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        idx_next  = idx_reg;
        last_next = last_reg;
        busy_next = busy_reg;
        if (emit) begin
            idx_next = idx_reg + IdxW'(1);
        end
        if (emit_done) begin
            busy_next = 1'b0;
        end
        if (accept && new_count != '0) begin
            idx_next  = '0;
            last_next = IdxW'(new_count - CntW'(1));
            busy_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            case (cur.kind)
                mbrtu_pkg::ENT_BYTE: begin
                    m_data_next.out_byte   = cur.value;
                    m_data_next.byte_valid = 1'b1;
                end
                mbrtu_pkg::ENT_CRC_LO: begin
                    m_data_next.out_byte   = tx_crc_reg[7:0];
                    m_data_next.byte_valid = 1'b1;
                end
                mbrtu_pkg::ENT_CRC_HI: begin
                    m_data_next.out_byte   = tx_crc_reg[15:8];
                    m_data_next.byte_valid = 1'b1;
                    m_data_next.frame_last = 1'b1;
                end
                default: begin
                    m_data_next.response_checked = 1'b1;
                    m_data_next.crc_ok           = cur.value[0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_crc_reg          <= mbrtu_pkg::CRC_INIT;
            data_remaining_reg  <= '0;
            pending_kind_reg    <= '0;
            expected_length_reg <= '0;
            received_count_reg  <= '0;
            rx_crc_reg          <= mbrtu_pkg::CRC_INIT;
            trailing_pair_reg   <= '0;
            tx_open_reg         <= 1'b0;
            idx_reg             <= '0;
            last_reg            <= '0;
            busy_reg            <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            tx_crc_reg          <= tx_crc_next;
            data_remaining_reg  <= data_remaining_next;
            pending_kind_reg    <= pending_kind_next;
            expected_length_reg <= expected_length_next;
            received_count_reg  <= received_count_next;
            rx_crc_reg          <= rx_crc_next;
            trailing_pair_reg   <= trailing_pair_next;
            tx_open_reg         <= tx_open_next;
            idx_reg             <= idx_next;
            last_reg            <= last_next;
            busy_reg            <= busy_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept && new_count != '0) begin
            plan_reg <= plan_new;
        end
    end

    `MBRTU_ASSERT_NOW(a_count_bounded, 1'b1, received_count_reg <= expected_length_reg)
    `MBRTU_ASSERT_NOW(a_open_multi, tx_open_reg,
        pending_kind_reg == mbrtu_pkg::KIND_WRITE_MULTI_COIL ||
        pending_kind_reg == mbrtu_pkg::KIND_WRITE_MULTI_REG)
    `MBRTU_ASSERT_NEXT(a_start_crc_init, accept && s_data.action == mbrtu_pkg::ACT_START,
        tx_crc_reg == mbrtu_pkg::CRC_INIT)
    `MBRTU_ASSERT_NOW(a_crc_hi_last, emit && cur.kind == mbrtu_pkg::ENT_CRC_HI,
        idx_reg == last_reg)
    `MBRTU_ASSERT_NEXT(a_stall_holds_idx, busy_reg && !emit, $stable(idx_reg) && busy_reg)

endmodule
